// File: src/zrle_pkg.sv
// ----------------------------------------------------------------------------
// zrle_pkg
// Shared types and constants for the zero run length encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package zrle_pkg;

  // Run length counter width and limits
  localparam int RUN_W = 6;
  localparam logic [RUN_W-1:0] RUN_MAX    = 6'h3f;
  localparam logic [RUN_W-1:0] MERGED_MAX = 6'hf;
  localparam logic [RUN_W-1:0] HOLD_LIMIT = 6'd8;

  // Control byte tags
  localparam logic [7:0] ZERO_TAG   = 8'h40;
  localparam logic [7:0] MERGED_TAG = 8'h80;

  // Literal buffer depth per bank
  localparam int LITERAL_DEPTH_DEF = 64;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Input item kinds carried on tuser
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // One closed run, handed from front to back
  typedef struct packed {
    logic [7:0]       ctrl;    // control byte
    logic [RUN_W-1:0] nlit;    // literal bytes that follow
    logic             bank;    // literal buffer bank
    logic             is_end;  // run closed by an end item
  } cmd_t;

  // Back reports a bank fully read out
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_done_t;

  typedef enum logic [1:0] {
    BK_CMD,
    BK_READ,
    BK_WAIT
  } back_state_t;

endpackage

`default_nettype wire

// File: src/zrle_ram.sv
// ----------------------------------------------------------------------------
// zrle_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module zrle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/zrle_queue.sv
// ----------------------------------------------------------------------------
// zrle_queue
// Short command FIFO between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
`default_nettype none

module zrle_queue
  import zrle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/zrle_front.sv
// ----------------------------------------------------------------------------
// zrle_front
// Accepts input beats, tracks the open run, buffers literals and issues one
// command for each closed run that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module zrle_front
  import zrle_pkg::*;
#(
  parameter int LITERAL_DEPTH = LITERAL_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [7:0]                         s_tdata,
  input  wire logic                               s_tuser,
  output logic                                    q_push,
  output cmd_t                                    q_cmd,
  input  wire logic                               q_full,
  input  wire bank_done_t                         done,
  output logic                                    ram_we,
  output logic [$clog2(2*LITERAL_DEPTH)-1:0]      ram_addr,
  output logic [7:0]                              ram_data
);

  localparam int IW = $clog2(LITERAL_DEPTH);

  logic             started,    started_next;
  logic             zero_run,   zero_run_next;
  logic [RUN_W-1:0] run_count,  run_count_next;
  logic [2:0]       held_zeros, held_zeros_next;
  logic             cur_bank,   cur_bank_next;
  logic [1:0]       busy,       busy_next;

  logic             accept;
  logic             is_end;
  logic             is_zero;
  logic             close;
  logic             emit_zero;
  logic [RUN_W-1:0] base;

  // Stall while the queue is full or a bank that may be written is draining
  assign s_tready = !q_full && !busy[cur_bank] &&
                    !(started && !zero_run && busy[!cur_bank]);

  always_comb begin
    accept  = s_tvalid && s_tready;
    is_end  = (s_tuser == OP_END);
    is_zero = (s_tdata == 8'h00);

    // Decide whether the open run closes on this beat
    close = started && (is_end || (is_zero != zero_run) || (run_count >= RUN_MAX) ||
            ((held_zeros != 3'd0) && (run_count >= MERGED_MAX)));
    emit_zero = is_end || (run_count >= HOLD_LIMIT);

    // Build the command for the closing run
    q_cmd.bank   = cur_bank;
    q_cmd.is_end = is_end;
    if (zero_run) begin
      q_cmd.ctrl = ZERO_TAG | {2'b00, run_count};
      q_cmd.nlit = '0;
    end else begin
      q_cmd.nlit = run_count;
      if (held_zeros != 3'd0) begin
        q_cmd.ctrl = MERGED_TAG | {1'b0, held_zeros, run_count[3:0]};
      end else begin
        q_cmd.ctrl = {2'b00, run_count};
      end
    end
    q_push = accept && close && (!zero_run || emit_zero);

    started_next    = started;
    zero_run_next   = zero_run;
    run_count_next  = run_count;
    held_zeros_next = held_zeros;
    cur_bank_next   = cur_bank;
    base            = run_count;
    ram_we          = 1'b0;

    if (accept) begin
      if (is_end) begin
        // Flush and return to idle
        started_next    = 1'b0;
        zero_run_next   = 1'b0;
        run_count_next  = '0;
        held_zeros_next = 3'd0;
        if (close && !zero_run) begin
          cur_bank_next = !cur_bank;
        end
      end else begin
        if (!started) begin
          started_next  = 1'b1;
          zero_run_next = is_zero;
          base          = '0;
        end else if (close) begin
          zero_run_next = is_zero;
          base          = '0;
          if (zero_run) begin
            held_zeros_next = emit_zero ? 3'd0 : run_count[2:0];
          end else begin
            held_zeros_next = 3'd0;
            cur_bank_next   = !cur_bank;
          end
        end
        ram_we         = !is_zero;
        run_count_next = base + 1'b1;
      end
    end

    ram_addr = {cur_bank_next, IW'(base)};
    ram_data = s_tdata;

    // Track banks with literals still to be read by the back
    busy_next = busy;
    if (done.valid) begin
      busy_next[done.bank] = 1'b0;
    end
    if (q_push && (q_cmd.nlit != '0)) begin
      busy_next[q_cmd.bank] = 1'b1;
    end
  end

  // Hold run state
  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      zero_run   <= 1'b0;
      run_count  <= '0;
      held_zeros <= 3'd0;
      cur_bank   <= 1'b0;
      busy       <= 2'b00;
    end else begin
      started    <= started_next;
      zero_run   <= zero_run_next;
      run_count  <= run_count_next;
      held_zeros <= held_zeros_next;
      cur_bank   <= cur_bank_next;
      busy       <= busy_next;
    end
  end

endmodule

`default_nettype wire

// File: src/zrle_back.sv
// ----------------------------------------------------------------------------
// zrle_back
// Pops commands, sends the control byte, then reads the literal bytes of the
// run out of the buffer one beat at a time into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module zrle_back
  import zrle_pkg::*;
#(
  parameter int LITERAL_DEPTH = LITERAL_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               q_valid,
  input  wire cmd_t                               q_cmd,
  output logic                                    q_pop,
  output bank_done_t                              done,
  output logic                                    rd_en,
  output logic [$clog2(2*LITERAL_DEPTH)-1:0]      rd_addr,
  input  wire logic [7:0]                         rd_data,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [7:0]                              m_tdata,
  output logic                                    m_tlast,
  output logic                                    m_tuser
);

  localparam int IW = $clog2(LITERAL_DEPTH);

  back_state_t      state, state_next;
  logic [RUN_W-1:0] idx,   idx_next;
  logic [RUN_W-1:0] nlit,  nlit_next;
  logic             bank,  bank_next;
  logic             is_end, is_end_next;
  logic             m_tvalid_next;
  logic [7:0]       m_tdata_next;
  logic             m_tlast_next;
  logic             m_tuser_next;
  logic             out_free;
  logic             last_lit;

  assign out_free = !m_tvalid || m_tready;
  assign last_lit = (idx == nlit - 1'b1);
  assign rd_addr  = {bank, IW'(idx)};

  // Next state and output register loads
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    nlit_next     = nlit;
    bank_next     = bank;
    is_end_next   = is_end;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next  = m_tdata;
    m_tlast_next  = m_tlast;
    m_tuser_next  = m_tuser;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    done.valid    = 1'b0;
    done.bank     = bank;

    unique case (state)
      BK_CMD: begin
        if (q_valid && out_free) begin
          q_pop         = 1'b1;
          m_tvalid_next = 1'b1;
          m_tdata_next  = q_cmd.ctrl;
          m_tlast_next  = (q_cmd.nlit == '0);
          m_tuser_next  = q_cmd.is_end && (q_cmd.nlit == '0);
          nlit_next     = q_cmd.nlit;
          bank_next     = q_cmd.bank;
          is_end_next   = q_cmd.is_end;
          idx_next      = '0;
          if (q_cmd.nlit != '0) begin
            state_next = BK_READ;
          end
        end
      end
      BK_READ: begin
        rd_en      = 1'b1;
        state_next = BK_WAIT;
      end
      BK_WAIT: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = rd_data;
          m_tlast_next  = last_lit;
          m_tuser_next  = is_end && last_lit;
          if (last_lit) begin
            done.valid = 1'b1;
            state_next = BK_CMD;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = BK_READ;
          end
        end
      end
      default: begin
        state_next = BK_CMD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_CMD;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    nlit    <= nlit_next;
    bank    <= bank_next;
    is_end  <= is_end_next;
    m_tdata <= m_tdata_next;
    m_tlast <= m_tlast_next;
    m_tuser <= m_tuser_next;
  end

endmodule

`default_nettype wire

// File: src/zero_run_length_encoder_unit.sv
// Order: a closed run's command passes through the command queue; the back then loads
// its control byte, then each literal byte by a buffer read and an output load.
// Throughput: one input beat per cycle, stalled while the two-entry command queue
// is full or while a literal bank that may be written is still being read out.
// Reset: rst is synchronous, active high; it clears run state, queue and output valid.
// The literal buffer is not cleared; only bytes of the current run are read.
// ----------------------------------------------------------------------------
// zero_run_length_encoder_unit
// Zero run length encoder: a front classifies bytes into zero and literal
// runs, a queue carries closed runs to a back that emits the encoded bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_run_length_encoder_unit
  import zrle_pkg::*;
#(
  parameter int LITERAL_DEPTH = LITERAL_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tuser,   // [0] op
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,   // last_of_run
  output logic            m_tuser    // [0] stream_end
);

  localparam int AW = $clog2(2*LITERAL_DEPTH);

  logic          q_push;
  cmd_t          q_cmd;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  cmd_t          q_head;
  bank_done_t    done;
  logic          ram_we;
  logic [AW-1:0] ram_wr_addr;
  logic [7:0]    ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [7:0]    ram_rd_data;

  zrle_front #(
    .LITERAL_DEPTH(LITERAL_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .q_full  (q_full),
    .done    (done),
    .ram_we  (ram_we),
    .ram_addr(ram_wr_addr),
    .ram_data(ram_wr_data)
  );

  zrle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_cmd  (q_head)
  );

  zrle_ram #(
    .WIDTH(8),
    .DEPTH(2*LITERAL_DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  zrle_back #(
    .LITERAL_DEPTH(LITERAL_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_head),
    .q_pop   (q_pop),
    .done    (done),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  // Stream end always closes the results of its beat
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("stream end without last");

  // Front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full command queue");

  // Literal buffer is never written where the back is reading
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_rd_en && ram_we) |-> (ram_rd_addr != ram_wr_addr))
    else $error("literal buffer read and write collide");

endmodule

`default_nettype wire

// File: tb/tb_zero_run_length_encoder_unit.sv
// ----------------------------------------------------------------------------
// tb_zero_run_length_encoder_unit
// Self-checking bench for the zero run length encoder. Directed streams hit
// the run-closing corner cases, then random streams of zero and literal runs
// with random lengths drive the unit under bursty input and a stalling
// output. A scoreboard class predicts every encoded beat and checks the output
// stream in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_zero_run_length_encoder_unit;
  import zrle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 245;      // directed part plus random streams
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS = 10;

  // One encoded output beat
  typedef struct packed {
    logic [7:0] code;
    logic       last_of_run;
    logic       stream_end;
  } enc_beat_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SLOW
  } rx_mode_t;

  // Encoder prediction and in-order output check
  class zrle_scoreboard;
    enc_beat_t  expected_q[$];
    enc_beat_t  step_q[$];
    int         mismatch_count;
    bit         open_run;
    bit         in_zero_run;
    logic [5:0] run_len;
    logic [2:0] held_zeros;
    logic [7:0] lit_buf[LITERAL_DEPTH_DEF];

    function new();
      mismatch_count = 0;
      open_run = 0;
      in_zero_run = 0;
      run_len = '0;
      held_zeros = '0;
    endfunction

    function void push_code(logic [7:0] b);
      enc_beat_t beat;
      beat.code = b;
      beat.last_of_run = 1'b0;
      beat.stream_end = 1'b0;
      step_q.push_back(beat);
    endfunction

    // Emit the open run; a short zero run not at the end is held back
    function void close_run(bit at_end);
      if (in_zero_run) begin
        if (!at_end && run_len < HOLD_LIMIT) begin
          held_zeros = run_len[2:0];
        end else begin
          held_zeros = '0;
          push_code(ZERO_TAG | {2'b00, run_len});
        end
      end else begin
        if (held_zeros != 0) begin
          push_code(MERGED_TAG | {1'b0, held_zeros, run_len[3:0]});
          held_zeros = '0;
        end else begin
          push_code({2'b00, run_len});
        end
        for (int k = 0; k < run_len; k++) push_code(lit_buf[k]);
      end
    endfunction

    // Advance the encoder state by one accepted input beat
    function void note_input(logic op, logic [7:0] b);
      enc_beat_t tail;
      bit        is_zero;
      step_q.delete();
      if (op == OP_END) begin
        if (open_run) close_run(1'b1);
        open_run = 0;
        in_zero_run = 0;
        run_len = '0;
        held_zeros = '0;
      end else begin
        is_zero = (b == 8'h00);
        if (!open_run) begin
          open_run = 1;
          in_zero_run = is_zero;
          run_len = '0;
        end else if (is_zero != in_zero_run || run_len >= RUN_MAX ||
                     (held_zeros != 0 && run_len >= MERGED_MAX)) begin
          close_run(1'b0);
          run_len = '0;
          in_zero_run = is_zero;
        end
        if (!in_zero_run) lit_buf[run_len] = b;
        run_len = run_len + 6'd1;
      end
      if (step_q.size() > 0) begin
        tail = step_q.pop_back();
        tail.last_of_run = 1'b1;
        tail.stream_end = (op == OP_END);
        step_q.push_back(tail);
      end
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    // Compare one output beat with the oldest expectation
    function void check_result(logic [7:0] code, logic last_of_run, logic stream_end);
      enc_beat_t want;
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected beat: byte %02h last %0b end %0b",
                   code, last_of_run, stream_end);
      end else begin
        want = expected_q.pop_front();
        if (want.code !== code || want.last_of_run !== last_of_run ||
            want.stream_end !== stream_end) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"beat mismatch: expected byte %02h last %0b end %0b, ",
                      "got byte %02h last %0b end %0b"},
                     want.code, want.last_of_run, want.stream_end,
                     code, last_of_run, stream_end);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = OP_DATA;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  zrle_scoreboard sb = new();
  int       items_sent = 0;
  int       burst_left = 0;
  int       cycle_count = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  zero_run_length_encoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stall the output side: free-running, coin-flip and mostly-stalled stretches
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: begin
        m_tready <= 1'b1;
      end
      RX_COIN: begin
        m_tready <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        m_tready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // Check every output beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
  end

  // Drive one input beat; insert a random gap when the current burst runs out
  task automatic send_beat(input logic op, input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                              : $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= b;
    burst_left--;
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, b);
    items_sent++;
  endtask

  task automatic send_end();
    send_beat(OP_END, 8'($urandom_range(0, 255)));
  endtask

  // Send a run of zero or non-zero bytes
  task automatic send_run(input bit zeros, input int len);
    for (int i = 0; i < len; i++)
      send_beat(OP_DATA, zeros ? 8'h00 : 8'($urandom_range(1, 255)));
  endtask

  initial begin
    int pick;
    int zero_len;
    int lit_len;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // end with nothing open
    send_end();
    // single zero then end: short zero run flushed, never held
    send_beat(OP_DATA, 8'h00);
    send_end();
    // short zero run merged into the following literal run
    send_run(1'b1, 3);
    send_beat(OP_DATA, 8'hff);
    send_beat(OP_DATA, 8'h01);
    send_beat(OP_DATA, 8'h80);
    send_end();
    // literal run closed by zeros, zeros flushed by end
    send_beat(OP_DATA, 8'h7f);
    send_run(1'b1, 2);
    send_end();
    // zero run of eight is emitted on its own
    send_run(1'b1, 8);
    send_beat(OP_DATA, 8'h01);
    send_end();
    // two literals, then end twice
    send_beat(OP_DATA, 8'h55);
    send_beat(OP_DATA, 8'haa);
    send_end();
    send_end();

    // Random streams: mostly zero run / literal run pairs, some stray ends
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 99) < 5) begin
        send_end();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) zero_len = 0;
        else if (pick < 65) zero_len = $urandom_range(1, 7);
        else if (pick < 90) zero_len = $urandom_range(8, 20);
        else zero_len = $urandom_range(56, 70);
        pick = $urandom_range(0, 99);
        if (pick < 55) lit_len = $urandom_range(1, 14);
        else if (pick < 88) lit_len = $urandom_range(14, 18);
        else lit_len = $urandom_range(56, 70);
        send_run(1'b1, zero_len);
        send_run(1'b0, lit_len);
        if ($urandom_range(0, 99) < 12) send_end();
      end
    end
    send_end();

    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain the expected beats, then watch for strays
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
src/zrle_pkg.sv
src/zrle_ram.sv
src/zrle_queue.sv
src/zrle_front.sv
src/zrle_back.sv
src/zero_run_length_encoder_unit.sv
tb/tb_zero_run_length_encoder_unit.sv
